// ===== rtl/core/dedup_request_queue_defines.svh =====
// Assertion macros shared by the dedup request queue RTL.
`ifndef DEDUP_REQUEST_QUEUE_DEFINES_SVH
`define DEDUP_REQUEST_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DRQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define DRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/drq_pkg.sv =====
// Types, constants and helper functions of the dedup request queue.
`timescale 1ns / 1ps

package drq_pkg;

	// Queue capacity and derived widths.
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int HELD_W = $clog2(DEPTH + 1);

	// Fixed field widths.
	localparam int ID_W  = 24;
	localparam int POS_W = 6;
	localparam int OCC_W = 7;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_TAKE   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_DUP   = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   item_id;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   out_id;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} res_t;

	// Access request from the sequencer to the entry memory.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ID_W-1:0]   wr_data;
	} mem_req_t;

	// Entry count as reported on the occupancy field.
	function automatic logic [OCC_W-1:0] occ_of(logic [HELD_W-1:0] h);
		logic [HELD_W+OCC_W-1:0] w;
		w = {{OCC_W{1'b0}}, h};
		return w[OCC_W-1:0];
	endfunction

	// Zero-extend a memory index to the width of the entry count.
	function automatic logic [HELD_W-1:0] zext_ptr(logic [ADDR_W-1:0] p);
		logic [HELD_W+ADDR_W-1:0] w;
		w = {{HELD_W{1'b0}}, p};
		return w[HELD_W-1:0];
	endfunction

endpackage

// ===== rtl/core/drq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module drq_ram #(
	parameter int Words = 64,
	parameter int Width = 24,
	parameter int AddrW = $clog2(Words)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data
);

	logic [Width-1:0] mem [Words];
	logic [Width-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/drq_ctrl.sv =====
// Command sequencer: searches, shifts and updates the queue held in the entry RAM.
`timescale 1ns / 1ps
`include "dedup_request_queue_defines.svh"

module drq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  drq_pkg::req_t             req,
	output logic                      busy,
	output drq_pkg::mem_req_t         mem,
	input  logic [drq_pkg::ID_W-1:0]  rdata,
	output drq_pkg::res_t             res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT_UP,
		ST_HEAD_WR,
		ST_TAKE_RD,
		ST_SHIFT_DN,
		ST_READ_RD
	} state_t;

	state_t                          state_q, state_nx;
	logic [drq_pkg::HELD_W-1:0]      held_q, held_nx;
	drq_pkg::cmd_t                   cmd_q, cmd_nx;
	logic [drq_pkg::ID_W-1:0]        id_q, id_nx;
	logic [drq_pkg::ADDR_W-1:0]      ptr_q, ptr_nx;
	logic                            srch_v_q, srch_v_nx;
	logic                            found_q, found_nx;
	logic [drq_pkg::ID_W-1:0]        res_id_q, res_id_nx;

	logic                            full;
	logic [drq_pkg::HELD_W-1:0]      held_m1;
	logic [drq_pkg::HELD_W-1:0]      ptr_w;
	logic [drq_pkg::HELD_W-1:0]      ptr_p2;
	logic [drq_pkg::HELD_W-1:0]      ptr_m2;
	logic [drq_pkg::HELD_W-1:0]      top_h;
	logic [drq_pkg::HELD_W-1:0]      top_m1;
	logic [drq_pkg::HELD_W+drq_pkg::POS_W-1:0] pos_w;
	logic [drq_pkg::HELD_W+drq_pkg::POS_W-1:0] held_w;
	logic                            hit;
	logic                            last;

	assign full    = held_q == drq_pkg::HELD_W'(drq_pkg::DEPTH);
	assign held_m1 = held_q - drq_pkg::HELD_W'(1);
	assign ptr_w   = drq_pkg::zext_ptr(ptr_q);
	assign ptr_p2  = ptr_w + drq_pkg::HELD_W'(2);
	assign ptr_m2  = ptr_w - drq_pkg::HELD_W'(2);
	assign pos_w   = {{drq_pkg::HELD_W{1'b0}}, req.position};
	assign held_w  = {{drq_pkg::POS_W{1'b0}}, held_q};

	// Search compare on the entry that the RAM returns this cycle.
	assign hit    = srch_v_q && (rdata == id_q);
	assign last   = !srch_v_q || (ptr_w == held_m1);
	assign top_h  = hit ? ptr_w : held_q;
	assign top_m1 = top_h - drq_pkg::HELD_W'(1);

	assign busy = state_q != ST_IDLE;

	// Next-state, memory access and result logic.
	always_comb begin
		state_nx  = state_q;
		held_nx   = held_q;
		cmd_nx    = cmd_q;
		id_nx     = id_q;
		ptr_nx    = ptr_q;
		srch_v_nx = srch_v_q;
		found_nx  = found_q;
		res_id_nx = res_id_q;
		mem       = '0;
		res.valid = 1'b0;
		res.rsp.status = drq_pkg::STAT_OK;
		res.rsp.out_id = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_nx = req.cmd;
					id_nx  = req.item_id;
					case (req.cmd)
						drq_pkg::CMD_APPEND, drq_pkg::CMD_INSERT: begin
							// Walk the held entries from the head looking for the ID.
							state_nx = ST_SEARCH;
							ptr_nx   = '0;
							if (held_q != '0) begin
								mem.rd_en   = 1'b1;
								mem.rd_addr = '0;
								srch_v_nx   = 1'b1;
							end else begin
								srch_v_nx = 1'b0;
							end
						end
						drq_pkg::CMD_TAKE: begin
							if (held_q == '0) begin
								res.valid      = 1'b1;
								res.rsp.status = drq_pkg::STAT_EMPTY;
							end else begin
								mem.rd_en   = 1'b1;
								mem.rd_addr = '0;
								state_nx    = ST_TAKE_RD;
							end
						end
						drq_pkg::CMD_READ: begin
							if (pos_w >= held_w) begin
								res.valid      = 1'b1;
								res.rsp.status = drq_pkg::STAT_EMPTY;
							end else begin
								mem.rd_en   = 1'b1;
								mem.rd_addr = pos_w[drq_pkg::ADDR_W-1:0];
								state_nx    = ST_READ_RD;
							end
						end
						default: begin
							state_nx = ST_IDLE;
						end
					endcase
				end
			end

			ST_SEARCH: begin
				if (hit || last) begin
					if (cmd_q == drq_pkg::CMD_APPEND) begin
						// Append: reject a duplicate or a full queue, else write at the tail.
						res.valid = 1'b1;
						state_nx  = ST_IDLE;
						if (hit) begin
							res.rsp.status = drq_pkg::STAT_DUP;
						end else if (full) begin
							res.rsp.status = drq_pkg::STAT_FULL;
						end else begin
							mem.wr_en   = 1'b1;
							mem.wr_addr = held_q[drq_pkg::ADDR_W-1:0];
							mem.wr_data = id_q;
							held_nx     = held_q + drq_pkg::HELD_W'(1);
						end
					end else if (!hit && full) begin
						res.valid      = 1'b1;
						res.rsp.status = drq_pkg::STAT_FULL;
						state_nx       = ST_IDLE;
					end else begin
						// Insert: move every entry below the gap (or the tail) up one.
						found_nx = hit;
						if (top_h == '0) begin
							mem.wr_en   = 1'b1;
							mem.wr_addr = '0;
							mem.wr_data = id_q;
							held_nx     = hit ? held_q : held_q + drq_pkg::HELD_W'(1);
							res.valid   = 1'b1;
							state_nx    = ST_IDLE;
						end else begin
							mem.rd_en   = 1'b1;
							mem.rd_addr = top_m1[drq_pkg::ADDR_W-1:0];
							ptr_nx      = top_h[drq_pkg::ADDR_W-1:0];
							state_nx    = ST_SHIFT_UP;
						end
					end
				end else begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = ptr_q + drq_pkg::ADDR_W'(1);
					ptr_nx      = ptr_q + drq_pkg::ADDR_W'(1);
				end
			end

			ST_SHIFT_UP: begin
				// Copy entry ptr-1 into ptr while fetching the next lower one.
				mem.wr_en   = 1'b1;
				mem.wr_addr = ptr_q;
				mem.wr_data = rdata;
				if (ptr_q == drq_pkg::ADDR_W'(1)) begin
					state_nx = ST_HEAD_WR;
				end else begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = ptr_m2[drq_pkg::ADDR_W-1:0];
					ptr_nx      = ptr_q - drq_pkg::ADDR_W'(1);
				end
			end

			ST_HEAD_WR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = '0;
				mem.wr_data = id_q;
				held_nx     = found_q ? held_q : held_q + drq_pkg::HELD_W'(1);
				res.valid   = 1'b1;
				state_nx    = ST_IDLE;
			end

			ST_TAKE_RD: begin
				res_id_nx = rdata;
				if (held_q == drq_pkg::HELD_W'(1)) begin
					held_nx        = '0;
					res.valid      = 1'b1;
					res.rsp.out_id = rdata;
					state_nx       = ST_IDLE;
				end else begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = drq_pkg::ADDR_W'(1);
					ptr_nx      = '0;
					state_nx    = ST_SHIFT_DN;
				end
			end

			ST_SHIFT_DN: begin
				// Copy entry ptr+1 into ptr, closing the gap at the head.
				mem.wr_en   = 1'b1;
				mem.wr_addr = ptr_q;
				mem.wr_data = rdata;
				if (ptr_p2 == held_q) begin
					held_nx        = held_m1;
					res.valid      = 1'b1;
					res.rsp.out_id = res_id_q;
					state_nx       = ST_IDLE;
				end else begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = ptr_p2[drq_pkg::ADDR_W-1:0];
					ptr_nx      = ptr_q + drq_pkg::ADDR_W'(1);
				end
			end

			ST_READ_RD: begin
				res.valid      = 1'b1;
				res.rsp.out_id = rdata;
				state_nx       = ST_IDLE;
			end

			default: begin
				state_nx = ST_IDLE;
			end
		endcase

		res.rsp.occupancy = drq_pkg::occ_of(held_nx);
	end

	// Control state and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
		end else begin
			state_q <= state_nx;
			held_q  <= held_nx;
		end
	end

	// Command payload and walk pointers.
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_nx;
		id_q     <= id_nx;
		ptr_q    <= ptr_nx;
		srch_v_q <= srch_v_nx;
		found_q  <= found_nx;
		res_id_q <= res_id_nx;
	end

	`DRQ_ASSERT_NOW(a_held_max, 1'b1, held_q <= drq_pkg::HELD_W'(drq_pkg::DEPTH), "count above depth")
	`DRQ_ASSERT_NOW(a_no_rw_clash, mem.rd_en && mem.wr_en, mem.rd_addr != mem.wr_addr, "read and write hit one entry")
	`DRQ_ASSERT_NOW(a_idle_result, res.valid && (state_q == ST_IDLE), start, "result from idle without a command")
	`DRQ_ASSERT_NEXT(a_held_only_on_result, !res.valid, $stable(held_q), "count changed without a result")

endmodule

// ===== rtl/core/dedup_request_queue.sv =====
// Top level of the dedup request queue: entry RAM, sequencer and result register.
//
//   Channel   Signals                 Transfer condition
//   command   start, busy, request    start high and busy low at a rising edge
//   result    done, result            done high (one cycle, cannot be stalled)
//
// Each command produces exactly one result, in command order. A take on an empty queue
// or a read beyond the count is answered from idle without touching the RAM; a read
// fetches one entry; a take reads the head and moves every other entry one place toward
// the head; an append compares entries from the head until it finds the ID or reaches
// the tail, then writes at the tail. An insert searches the same way, moves the entries
// below the found copy (or all of them) one place toward the tail, then writes the head.
// Busy falls at the edge that raises done, so the next command can transfer at the
// edge that takes the result. After reset the queue is empty; the RAM needs no clearing.
`timescale 1ns / 1ps

module dedup_request_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  drq_pkg::req_t  request,
	output logic           done,
	output drq_pkg::rsp_t  result
);

	drq_pkg::mem_req_t            mem;
	logic [drq_pkg::ID_W-1:0]     rdata;
	drq_pkg::res_t                res;
	logic                         done_q;
	drq_pkg::rsp_t                result_q;

	// Queue entry storage.
	drq_ram #(
		.Words (drq_pkg::DEPTH),
		.Width (drq_pkg::ID_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rdata),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (mem.wr_data)
	);

	// Command sequencer.
	drq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (request),
		.busy   (busy),
		.mem    (mem),
		.rdata  (rdata),
		.res    (res)
	);

	// Result strobe register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			result_q <= res.rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the dedup request queue: driver, monitor and scoreboard.
`timescale 1ns / 1ps

module testbench;

	localparam int TOTAL_ITEMS = 950;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 2 * drq_pkg::DEPTH + 8;

	// Phases of the random part.
	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	// Shadow copy of the queue and the results it predicts, oldest first.
	class queue_scoreboard;
		logic [drq_pkg::ID_W-1:0] shadow[$];
		drq_pkg::rsp_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Position of id in the shadow queue, or -1 when it is not queued.
		function int locate(logic [drq_pkg::ID_W-1:0] id);
			foreach (shadow[i]) begin
				if (shadow[i] == id)
					return i;
			end
			return -1;
		endfunction

		// Apply one accepted command to the shadow queue and record its result.
		function void note_command(drq_pkg::req_t r);
			drq_pkg::rsp_t e;
			int idx;
			e.status = drq_pkg::STAT_OK;
			e.out_id = '0;
			case (r.cmd)
				drq_pkg::CMD_APPEND: begin
					idx = locate(r.item_id);
					if (idx >= 0)
						e.status = drq_pkg::STAT_DUP;
					else if (shadow.size() >= drq_pkg::DEPTH)
						e.status = drq_pkg::STAT_FULL;
					else
						shadow.insert(shadow.size(), r.item_id);
				end
				drq_pkg::CMD_INSERT: begin
					// A queued copy leaves first, so moving an ID never overflows.
					idx = locate(r.item_id);
					if (idx >= 0)
						shadow.delete(idx);
					if (shadow.size() >= drq_pkg::DEPTH)
						e.status = drq_pkg::STAT_FULL;
					else
						shadow.push_front(r.item_id);
				end
				drq_pkg::CMD_TAKE: begin
					if (shadow.size() == 0)
						e.status = drq_pkg::STAT_EMPTY;
					else
						e.out_id = shadow.pop_front();
				end
				default: begin
					if (r.position >= shadow.size())
						e.status = drq_pkg::STAT_EMPTY;
					else
						e.out_id = shadow[r.position];
				end
			endcase
			e.occupancy = drq_pkg::OCC_W'(shadow.size());
			pending.insert(pending.size(), e);
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		// Compare one result transfer with the oldest prediction.
		task check_result(drq_pkg::rsp_t r);
			drq_pkg::rsp_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending: status %0d id %06h occ %0d",
					r.status, r.out_id, r.occupancy));
			end else begin
				want = pending.pop_front();
				if (r.status !== want.status)
					report($sformatf("status %0d, predicted %0d", r.status, want.status));
				if (r.out_id !== want.out_id)
					report($sformatf("out_id %06h, predicted %06h", r.out_id, want.out_id));
				if (r.occupancy !== want.occupancy)
					report($sformatf("occupancy %0d, predicted %0d", r.occupancy,
						want.occupancy));
			end
		endtask

		function int outstanding();
			return pending.size();
		endfunction

		function logic [drq_pkg::ID_W-1:0] queued_id();
			return shadow[$urandom_range(0, shadow.size() - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	drq_pkg::req_t request;
	logic done;
	drq_pkg::rsp_t result;

	queue_scoreboard sb;
	int burst_left;
	int sent;
	int cycles;

	dedup_request_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Every result transfer is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Present one command and hold it until the block takes it.
	task automatic send_command(input drq_pkg::cmd_t c, input logic [drq_pkg::ID_W-1:0] id,
		input logic [drq_pkg::POS_W-1:0] pos);
		drq_pkg::req_t r;
		r.cmd = c;
		r.item_id = id;
		r.position = pos;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sb.note_command(r);
		@(negedge clk);
	endtask

	// Bursts of commands separated by random gaps, some bursts back to back.
	task automatic pace();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
	endtask

	task automatic issue(input drq_pkg::cmd_t c, input logic [drq_pkg::ID_W-1:0] id,
		input logic [drq_pkg::POS_W-1:0] pos);
		send_command(c, id, pos);
		pace();
		sent++;
	endtask

	// IDs come from the queue itself, from a tiny pool, or from the whole range.
	function automatic logic [drq_pkg::ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3 && sb.shadow.size() > 0)
			return sb.queued_id();
		if (r == 3)
			return ($urandom_range(0, 1) == 0) ? drq_pkg::ID_W'($urandom_range(0, 7)) : '1;
		return drq_pkg::ID_W'($urandom());
	endfunction

	// One random command whose mix depends on the phase.
	task automatic random_item(input phase_t ph);
		int r;
		int lim_app;
		int lim_ins;
		int lim_take;
		logic [drq_pkg::POS_W-1:0] pos;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				lim_app = 55;
				lim_ins = 80;
				lim_take = 88;
			end
			PH_DRAIN: begin
				lim_app = 10;
				lim_ins = 20;
				lim_take = 75;
			end
			default: begin
				lim_app = 25;
				lim_ins = 50;
				lim_take = 75;
			end
		endcase
		if ($urandom_range(0, 9) < 7 && sb.shadow.size() > 0)
			pos = drq_pkg::POS_W'($urandom_range(0, sb.shadow.size() - 1));
		else
			pos = drq_pkg::POS_W'($urandom());
		if (r < lim_app)
			issue(drq_pkg::CMD_APPEND, pick_id(), pos);
		else if (r < lim_ins)
			issue(drq_pkg::CMD_INSERT, pick_id(), pos);
		else if (r < lim_take)
			issue(drq_pkg::CMD_TAKE, drq_pkg::ID_W'($urandom()), pos);
		else
			issue(drq_pkg::CMD_READ, drq_pkg::ID_W'($urandom()), pos);
	endtask

	// Main sequence: reset, directed commands, random phases, drain.
	initial begin
		phase_t ph;
		int len;
		sb = new();
		cycles = 0;
		sent = 0;
		burst_left = 1;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty queue, extreme IDs, duplicates, moves to the head, reads in and out of range.
		issue(drq_pkg::CMD_TAKE, '0, '0);
		issue(drq_pkg::CMD_READ, '0, '0);
		issue(drq_pkg::CMD_APPEND, '0, '1);
		issue(drq_pkg::CMD_APPEND, '1, '0);
		issue(drq_pkg::CMD_APPEND, '0, '0);
		issue(drq_pkg::CMD_APPEND, 24'h123456, '0);
		issue(drq_pkg::CMD_INSERT, '1, '0);
		issue(drq_pkg::CMD_INSERT, 24'hABCDEF, '0);
		issue(drq_pkg::CMD_READ, '1, 6'd0);
		issue(drq_pkg::CMD_READ, '0, 6'd3);
		issue(drq_pkg::CMD_READ, '0, 6'd4);
		issue(drq_pkg::CMD_READ, '1, '1);
		issue(drq_pkg::CMD_INSERT, 24'h123456, '0);
		issue(drq_pkg::CMD_INSERT, 24'h123456, '0);
		issue(drq_pkg::CMD_APPEND, '1, '0);
		issue(drq_pkg::CMD_TAKE, '1, '1);
		issue(drq_pkg::CMD_READ, 24'h5A5A5A, 6'd1);
		issue(drq_pkg::CMD_TAKE, '0, '0);
		issue(drq_pkg::CMD_TAKE, '0, '0);
		issue(drq_pkg::CMD_TAKE, '0, '0);
		issue(drq_pkg::CMD_TAKE, '0, '0);
		issue(drq_pkg::CMD_READ, '0, '0);

		// Random phases that lean toward filling the queue, draining it, or mixing commands.
		while (sent < TOTAL_ITEMS) begin
			ph = phase_t'($urandom_range(0, 2));
			len = $urandom_range(30, 150);
			repeat (len) begin
				if (sent >= TOTAL_ITEMS)
					break;
				random_item(ph);
			end
		end

		start <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
